/* hw/rtl/cbf_pkg.sv */
// shared types and constants for the circular byte queue
// no dependencies; used by cbf_read_stage, byte_ring_buffer_block_transfer and the verif checker and test
package cbf_pkg;

    // default sizes
    localparam int DEPTH_DEF    = 256;
    localparam int MAX_XFER_DEF = 64;

    // fixed field widths
    localparam int CAP_W    = 9;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int FILL_W   = 9;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // command codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // control states
    typedef enum logic {
        ST_IDLE,
        ST_GET
    } state_t;

    // side info that travels with a read request through the memory stage
    typedef struct packed {
        logic              last;
        logic [FILL_W-1:0] fill;
    } rd_ctl_t;

endpackage

/* hw/rtl/cbf_read_stage.sv */
// byte store memory and its registered read stage
// depends on cbf_pkg for rd_ctl_t and field widths
module cbf_read_stage #(
    parameter int DEPTH = cbf_pkg::DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // write port
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [cbf_pkg::BYTE_W-1:0]       wr_data,
    // read request
    input  logic                             rd_issue,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    input  cbf_pkg::rd_ctl_t                 rd_ctl_in,
    // read result, held until consumed
    input  logic                             rd_consume,
    output logic                             rd_valid,
    output logic [cbf_pkg::BYTE_W-1:0]       rd_data,
    output cbf_pkg::rd_ctl_t                 rd_ctl_out
);

    logic [cbf_pkg::BYTE_W-1:0] byte_store_mem [DEPTH];
    logic [cbf_pkg::BYTE_W-1:0] rd_data_reg;
    cbf_pkg::rd_ctl_t           rd_ctl_reg;
    logic                       rd_valid_reg;
    logic                       rd_valid_next;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byte_store_mem[wr_addr] <= wr_data;
        end
    end

    // read port, data register holds while the stage is stalled
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_data_reg <= byte_store_mem[rd_addr];
            rd_ctl_reg  <= rd_ctl_in;
        end
    end

    // stage occupancy
    always_comb begin
        if (rd_issue) begin
            rd_valid_next = 1'b1;
        end else if (rd_consume) begin
            rd_valid_next = 1'b0;
        end else begin
            rd_valid_next = rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_valid   = rd_valid_reg;
    assign rd_data    = rd_data_reg;
    assign rd_ctl_out = rd_ctl_reg;

endmodule

/* hw/rtl/byte_ring_buffer_block_transfer.sv */
// circular byte queue with all-or-nothing block puts and gets.
// put items: one per cycle unless the output stalls or a capacity write waits; a status result
// is valid the cycle after the run's last item is taken. get of L bytes: the sequencer reads
// one byte per cycle through the single read port into the read stage and output register,
// while the output is not stalled; the next request is taken once the read stage has drained.
// reset (aresetn, synchronous): pointers, count, run state cleared, capacity 256; store kept.
module byte_ring_buffer_block_transfer #(
    parameter int DEPTH    = cbf_pkg::DEPTH_DEF,
    parameter int MAX_XFER = cbf_pkg::MAX_XFER_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // capacity register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbf_pkg::CAP_W-1:0]     cfg_data,
    // requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbf_pkg::S_DATA_W-1:0]  s_tdata,  // length[6:0], data_in[14:7], zero[15]
    input  logic                          s_tuser,  // cmd
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbf_pkg::M_DATA_W-1:0]  m_tdata,  // data_out[7:0], fill_level[16:8], zero[23:17]
    output logic                          m_tuser,  // ok
    output logic                          m_tlast   // last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > cbf_pkg::CAP_W) ? CNT_W : cbf_pkg::CAP_W;
    localparam int LW    = (CNT_W > cbf_pkg::LEN_W) ? CNT_W : cbf_pkg::LEN_W;

    // registers
    cbf_pkg::state_t               state_reg, state_next;
    logic [cbf_pkg::CAP_W-1:0]     capacity_reg;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic [PTR_W-1:0]              rp_reg, rp_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [cbf_pkg::LEN_W-1:0]     left_reg, left_next;
    logic                          refused_reg, refused_next;
    logic [cbf_pkg::LEN_W-1:0]     rem_reg, rem_next;

    logic                          m_valid_reg;
    logic                          m_ok_reg;
    logic [cbf_pkg::BYTE_W-1:0]    m_data_reg;
    logic                          m_last_reg;
    logic [cbf_pkg::FILL_W-1:0]    m_fill_reg;

    // request fields
    logic                          in_cmd;
    logic [cbf_pkg::LEN_W-1:0]     in_len;
    logic [cbf_pkg::BYTE_W-1:0]    in_din;

    // handshake and control
    logic                          in_fire;
    logic                          cfg_fire;
    logic                          out_free;
    logic                          rd_issue;
    logic                          rd_consume;
    logic                          rd_valid;
    logic [cbf_pkg::BYTE_W-1:0]    rd_data;
    cbf_pkg::rd_ctl_t              rd_ctl_in;
    cbf_pkg::rd_ctl_t              rd_ctl_out;

    // datapath
    logic [CMP_W-1:0]              cap_ext;
    logic [CNT_W-1:0]              cap_eff;
    logic [CNT_W-1:0]              room;
    logic [LW-1:0]                 len_ext;
    logic                          len_big;
    logic                          len_zero;
    logic                          put_first;
    logic                          put_refuse_eff;
    logic [cbf_pkg::LEN_W-1:0]     put_left_eff;
    logic                          wr_en;
    logic [CNT_W-1:0]              wp_inc;
    logic [CNT_W-1:0]              rp_inc;
    logic                          get_go;
    logic                          res_valid;
    logic                          res_ok;

    assign in_cmd = s_tuser;
    assign in_len = s_tdata[cbf_pkg::LEN_W-1:0];
    assign in_din = s_tdata[cbf_pkg::LEN_W +: cbf_pkg::BYTE_W];

    assign out_free   = !m_valid_reg || m_tready;
    assign rd_consume = rd_valid && out_free;
    assign in_fire    = s_tvalid && s_tready;
    assign cfg_fire   = cfg_valid && cfg_ready;

    // effective capacity: zero acts as one, above the store size clamps
    assign cap_ext = CMP_W'(capacity_reg);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_ext);
        end
    end

    // length checks
    assign room     = cap_eff - count_reg;
    assign len_ext  = LW'(in_len);
    assign len_big  = in_len > cbf_pkg::LEN_W'(MAX_XFER);
    assign len_zero = in_len == '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbf_pkg::ST_IDLE: begin
                if (get_go) begin
                    state_next = cbf_pkg::ST_GET;
                end
            end
            cbf_pkg::ST_GET: begin
                if (rd_issue && rem_reg == cbf_pkg::LEN_W'(1)) begin
                    state_next = cbf_pkg::ST_IDLE;
                end
            end
            default: state_next = cbf_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs, a pending capacity write goes before a request
    always_comb begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        rd_issue  = 1'b0;
        case (state_reg)
            cbf_pkg::ST_IDLE: begin
                s_tready  = !rd_valid && out_free && !cfg_valid;
                cfg_ready = !rd_valid;
            end
            cbf_pkg::ST_GET: begin
                rd_issue = !rd_valid || rd_consume;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // put run bookkeeping, pointer and count updates
    always_comb begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        refused_next   = refused_reg;
        rem_next       = rem_reg;
        wr_en          = 1'b0;
        get_go         = 1'b0;
        res_valid      = 1'b0;
        res_ok         = 1'b1;
        put_first      = left_reg == '0;
        put_refuse_eff = put_first ? (len_big || LW'(room) < len_ext) : refused_reg;
        put_left_eff   = put_first ? in_len : left_reg;
        wp_inc         = CNT_W'(wp_reg) + CNT_W'(1);
        rp_inc         = CNT_W'(rp_reg) + CNT_W'(1);

        if (in_fire && in_cmd == cbf_pkg::CMD_PUT) begin
            if (put_first && len_zero) begin
                res_valid = 1'b1;
            end else begin
                if (!put_refuse_eff && count_reg < cap_eff && CNT_W'(wp_reg) < cap_eff) begin
                    wr_en      = 1'b1;
                    wp_next    = (wp_inc == cap_eff) ? '0 : PTR_W'(wp_inc);
                    count_next = count_reg + CNT_W'(1);
                end
                left_next = put_left_eff - cbf_pkg::LEN_W'(1);
                if (left_next == '0) begin
                    res_valid    = 1'b1;
                    res_ok       = !put_refuse_eff;
                    refused_next = 1'b0;
                end else begin
                    refused_next = put_refuse_eff;
                end
            end
        end else if (in_fire && in_cmd == cbf_pkg::CMD_GET) begin
            if (len_zero) begin
                res_valid = 1'b1;
            end else if (len_big || LW'(count_reg) < len_ext) begin
                res_valid = 1'b1;
                res_ok    = 1'b0;
            end else begin
                get_go   = 1'b1;
                rem_next = in_len;
            end
        end

        // one byte read per cycle while a get streams and the output is not stalled
        if (rd_issue) begin
            rp_next    = (rp_inc >= cap_eff) ? '0 : PTR_W'(rp_inc);
            count_next = count_reg - CNT_W'(1);
            rem_next   = rem_reg - cbf_pkg::LEN_W'(1);
        end

        // capacity write empties the queue and drops any open run
        if (cfg_fire) begin
            wp_next      = '0;
            rp_next      = '0;
            count_next   = '0;
            left_next    = '0;
            refused_next = 1'b0;
            wr_en        = 1'b0;
            res_valid    = 1'b0;
        end
    end

    assign rd_ctl_in.last = rem_reg == cbf_pkg::LEN_W'(1);
    assign rd_ctl_in.fill = cbf_pkg::FILL_W'(count_next);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cbf_pkg::ST_IDLE;
            capacity_reg <= cbf_pkg::CAP_RESET;
            wp_reg       <= '0;
            rp_reg       <= '0;
            count_reg    <= '0;
            left_reg     <= '0;
            refused_reg  <= 1'b0;
            rem_reg      <= '0;
        end else begin
            state_reg    <= cfg_fire ? cbf_pkg::ST_IDLE : state_next;
            if (cfg_fire) begin
                capacity_reg <= cfg_data;
            end
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            count_reg    <= count_next;
            left_reg     <= left_next;
            refused_reg  <= refused_next;
            rem_reg      <= rem_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rd_consume || res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (rd_consume) begin
            m_ok_reg   <= 1'b1;
            m_data_reg <= rd_data;
            m_last_reg <= rd_ctl_out.last;
            m_fill_reg <= rd_ctl_out.fill;
        end else if (res_valid) begin
            m_ok_reg   <= res_ok;
            m_data_reg <= '0;
            m_last_reg <= 1'b1;
            m_fill_reg <= cbf_pkg::FILL_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(cbf_pkg::M_DATA_W - cbf_pkg::FILL_W - cbf_pkg::BYTE_W){1'b0}},
                       m_fill_reg, m_data_reg};

    // byte store and read stage
    cbf_read_stage #(
        .DEPTH(DEPTH)
    ) u_read_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_addr    (wp_reg),
        .wr_data    (in_din),
        .rd_issue   (rd_issue),
        .rd_addr    (rp_reg),
        .rd_ctl_in  (rd_ctl_in),
        .rd_consume (rd_consume),
        .rd_valid   (rd_valid),
        .rd_data    (rd_data),
        .rd_ctl_out (rd_ctl_out)
    );

    // stored bytes never exceed the capacity in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_eff)
        else $error("stored count above capacity");

    // no request taken while a read result is still in the stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> !rd_valid)
        else $error("request accepted with read stage busy");

    // a streaming get always has bytes left to read
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cbf_pkg::ST_GET |-> rem_reg != '0)
        else $error("get state with no bytes left");

    // the last byte of a get leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid && rd_ctl_out.last |-> state_reg == cbf_pkg::ST_IDLE)
        else $error("last byte read while get still streaming");

    // every read issue decrements the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue && !cfg_fire |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("count not decremented on read");

endmodule

/* verif/byte_ring_buffer_block_transfer_checker.sv */
// scoreboard for the circular byte queue: mirrors the queue from accepted requests
// and capacity writes, and compares each accepted result with the oldest one owed
// depends on cbf_pkg
`timescale 1ns / 100ps

module byte_ring_buffer_block_transfer_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [cbf_pkg::CAP_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [cbf_pkg::S_DATA_W-1:0] s_tdata,   // length[6:0], data_in[14:7], zero[15]
    input  logic                         s_tuser,   // cmd
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [cbf_pkg::M_DATA_W-1:0] m_tdata,   // data_out[7:0], fill_level[16:8], zero[23:17]
    input  logic                         m_tuser,   // ok
    input  logic                         m_tlast,   // last
    output int                           mismatch_count,
    output int                           results_owed,
    output int                           bytes_held
);

    typedef struct packed {
        logic                       ok;
        logic [cbf_pkg::BYTE_W-1:0] data;
        logic                       last;
        logic [cbf_pkg::FILL_W-1:0] fill;
    } byte_result_t;

    // mirrored queue state
    logic [cbf_pkg::BYTE_W-1:0] byte_mem [cbf_pkg::DEPTH_DEF];
    logic [7:0]                 wr_ptr;
    logic [7:0]                 rd_ptr;
    logic [cbf_pkg::FILL_W-1:0] held_bytes;
    logic [cbf_pkg::LEN_W-1:0]  run_left;
    logic                       run_refused;
    logic [cbf_pkg::CAP_W-1:0]  cap_reg;

    byte_result_t owed[$];

    // capacity in force: zero acts as one, oversize acts as the full store
    function automatic logic [cbf_pkg::CAP_W-1:0] usable_capacity();
        if (cap_reg == '0) begin
            return cbf_pkg::CAP_W'(1);
        end
        if (cap_reg > cbf_pkg::CAP_W'(cbf_pkg::DEPTH_DEF)) begin
            return cbf_pkg::CAP_W'(cbf_pkg::DEPTH_DEF);
        end
        return cap_reg;
    endfunction

    task automatic empty_queue();
        wr_ptr      = '0;
        rd_ptr      = '0;
        held_bytes  = '0;
        run_left    = '0;
        run_refused = 1'b0;
    endtask

    // fill level is taken after the state change that goes with the result
    task automatic owe_result(input logic ok, input logic [cbf_pkg::BYTE_W-1:0] data,
                              input logic last);
        byte_result_t r;
        r.ok   = ok;
        r.data = data;
        r.last = last;
        r.fill = held_bytes;
        owed.push_back(r);
    endtask

    // apply one accepted request and queue the results it causes
    task automatic advance_queue_state(input logic cmd, input logic [cbf_pkg::LEN_W-1:0] len,
                                       input logic [cbf_pkg::BYTE_W-1:0] din);
        logic [cbf_pkg::CAP_W-1:0]  cap;
        logic [cbf_pkg::BYTE_W-1:0] b;
        int                         k;
        cap = usable_capacity();
        if (cmd == cbf_pkg::CMD_PUT) begin
            if (run_left == '0 && len == '0) begin
                owe_result(1'b1, '0, 1'b1);
            end else begin
                // first byte of a run decides for the whole run
                if (run_left == '0) begin
                    run_refused = (len > cbf_pkg::MAX_XFER_DEF) || (cap - held_bytes < len);
                    run_left    = len;
                end
                if (!run_refused && held_bytes < cap && {1'b0, wr_ptr} < cap) begin
                    byte_mem[wr_ptr] = din;
                    wr_ptr = ({1'b0, wr_ptr} + 9'd1 == cap) ? 8'd0 : wr_ptr + 8'd1;
                    held_bytes++;
                end
                run_left--;
                if (run_left == '0) begin
                    owe_result(!run_refused, '0, 1'b1);
                    run_refused = 1'b0;
                end
            end
        end else if (len == '0) begin
            owe_result(1'b1, '0, 1'b1);
        end else if (len > cbf_pkg::MAX_XFER_DEF || held_bytes < len) begin
            owe_result(1'b0, '0, 1'b1);
        end else begin
            for (k = 0; k < len; k++) begin
                b      = byte_mem[rd_ptr];
                rd_ptr = ({1'b0, rd_ptr} + 9'd1 >= cap) ? 8'd0 : rd_ptr + 8'd1;
                held_bytes--;
                owe_result(1'b1, b, k == len - 1);
            end
        end
    endtask

    // watch all three channels at the rising edge
    always @(posedge aclk) begin
        byte_result_t got;
        byte_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < cbf_pkg::DEPTH_DEF; i++) begin
                byte_mem[i] = '0;
            end
            cap_reg = cbf_pkg::CAP_RESET;
            empty_queue();
            owed.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg = cfg_data;
                empty_queue();
            end
            if (s_tvalid && s_tready) begin
                advance_queue_state(s_tuser, s_tdata[6:0], s_tdata[14:7]);
            end
            if (m_tvalid && m_tready) begin
                got.ok   = m_tuser;
                got.data = m_tdata[7:0];
                got.last = m_tlast;
                got.fill = m_tdata[16:8];
                if (owed.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $write("%0t: result with nothing expected:", $realtime);
                        $display(" ok=%0d data=%02h last=%0d fill=%0d",
                                 got.ok, got.data, got.last, got.fill);
                    end
                    mismatch_count++;
                end else begin
                    want = owed.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $write("%0t: expected ok=%0d data=%02h last=%0d fill=%0d",
                                   $realtime, want.ok, want.data, want.last, want.fill);
                            $display(", got ok=%0d data=%02h last=%0d fill=%0d",
                                     got.ok, got.data, got.last, got.fill);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        results_owed = owed.size();
        bytes_held   = int'(held_bytes);
    end

endmodule

/* verif/byte_ring_buffer_block_transfer_test.sv */
// top of the circular byte queue testbench: clock, reset, capacity writes and request stimulus
// depends on cbf_pkg, byte_ring_buffer_block_transfer and byte_ring_buffer_block_transfer_checker
`timescale 1ns / 100ps

module byte_ring_buffer_block_transfer_test;

    localparam int STALL_LIMIT  = 10000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 40;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cbf_pkg::CAP_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cbf_pkg::S_DATA_W-1:0]   s_tdata;   // length[6:0], data_in[14:7], zero[15]
    logic                           s_tuser;   // cmd
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cbf_pkg::M_DATA_W-1:0]   m_tdata;   // data_out[7:0], fill_level[16:8], zero[23:17]
    logic                           m_tuser;   // ok
    logic                           m_tlast;   // last

    int mismatch_count;
    int results_owed;
    int bytes_held;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int quiet_cycles   = 0;
    int usable_cap     = cbf_pkg::DEPTH_DEF;

    // capacity per random phase, extremes and out-of-range values among them
    int cap_plan [8] = '{256, 1, 511, 37, 0, 200, 300, 64};

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    byte_ring_buffer_block_transfer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    byte_ring_buffer_block_transfer_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .bytes_held     (bytes_held)
    );

    // result side: random stalls, or a long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_served++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("byte_ring_buffer_block_transfer_test: done, errors");
            $finish;
        end
    end

    // one request, entered and left at a falling edge
    task automatic drive_request(input logic cmd, input logic [cbf_pkg::LEN_W-1:0] len,
                                 input logic [cbf_pkg::BYTE_W-1:0] dat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, dat, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // capacity write once all owed results are out and the block has settled
    task automatic write_capacity(input logic [cbf_pkg::CAP_W-1:0] value);
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        usable_cap = (value == '0) ? 1 :
                     (value > cbf_pkg::DEPTH_DEF) ? cbf_pkg::DEPTH_DEF : int'(value);
    endtask

    initial begin
        int phase;
        int sent;
        int room;
        int span;
        int run_len;
        int pick;
        int k;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = cbf_pkg::CMD_PUT;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero-length transfers and a get from the empty queue
        drive_request(cbf_pkg::CMD_GET, 7'd0, 8'h00);
        drive_request(cbf_pkg::CMD_PUT, 7'd0, 8'hFF);
        drive_request(cbf_pkg::CMD_GET, 7'd1, 8'h00);
        // short run, later length fields are don't-care
        drive_request(cbf_pkg::CMD_PUT, 7'd3, 8'h00);
        drive_request(cbf_pkg::CMD_PUT, 7'd127, 8'hFF);
        drive_request(cbf_pkg::CMD_PUT, 7'd0, 8'hA5);
        // get above the transfer limit is refused, then a good get
        drive_request(cbf_pkg::CMD_GET, 7'd127, 8'hFF);
        drive_request(cbf_pkg::CMD_GET, 7'd3, 8'h00);
        // get interleaved inside a put run
        drive_request(cbf_pkg::CMD_PUT, 7'd2, 8'h5A);
        drive_request(cbf_pkg::CMD_GET, 7'd0, 8'h00);
        drive_request(cbf_pkg::CMD_PUT, 7'd1, 8'h3C);
        drive_request(cbf_pkg::CMD_GET, 7'd2, 8'h00);
        // open run abandoned by a capacity write
        drive_request(cbf_pkg::CMD_PUT, 7'd5, 8'h11);
        drive_request(cbf_pkg::CMD_PUT, 7'd64, 8'h22);
        write_capacity(9'd3);
        // tiny queue: fill, refuse, wrap both pointers
        drive_request(cbf_pkg::CMD_PUT, 7'd3, 8'h81);
        drive_request(cbf_pkg::CMD_PUT, 7'd0, 8'h7E);
        drive_request(cbf_pkg::CMD_PUT, 7'd0, 8'h01);
        drive_request(cbf_pkg::CMD_PUT, 7'd1, 8'hEE);
        drive_request(cbf_pkg::CMD_GET, 7'd2, 8'h00);
        drive_request(cbf_pkg::CMD_PUT, 7'd2, 8'hC3);
        drive_request(cbf_pkg::CMD_PUT, 7'd0, 8'h3C);
        drive_request(cbf_pkg::CMD_GET, 7'd3, 8'h00);
        drive_request(cbf_pkg::CMD_GET, 7'd1, 8'h00);

        // long receiver hold-off so results back up into the input
        write_capacity(9'd256);
        hold_asked++;
        for (k = 0; k < 48; k++) begin
            drive_request(cbf_pkg::CMD_PUT, (k == 0) ? 7'd48 : 7'($urandom_range(127)),
                          8'($urandom_range(255)));
        end
        drive_request(cbf_pkg::CMD_GET, 7'd48, 8'($urandom_range(255)));
        drive_request(cbf_pkg::CMD_GET, 7'd0, 8'($urandom_range(255)));
        for (k = 0; k < 20; k++) begin
            drive_request(cbf_pkg::CMD_PUT, (k == 0) ? 7'd20 : 7'($urandom_range(127)),
                          8'($urandom_range(255)));
        end
        drive_request(cbf_pkg::CMD_GET, 7'd20, 8'($urandom_range(255)));

        // random phases over capacities and idle patterns
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 87;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            write_capacity(9'(cap_plan[phase]));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                room = usable_cap - bytes_held;
                if ($urandom_range(99) < 55) begin
                    // put run, mostly sized to fit the free space
                    span = (room > 64) ? 64 : room;
                    pick = $urandom_range(99);
                    if (pick < 60 && room > 0) begin
                        run_len = $urandom_range(1, (span > 12) ? 12 : span);
                    end else if (pick < 82 && room > 0) begin
                        run_len = $urandom_range(1, span);
                    end else if (pick < 90) begin
                        run_len = $urandom_range(1, 64);
                    end else if (pick < 97) begin
                        run_len = 0;
                    end else begin
                        run_len = $urandom_range(65, 72);
                    end
                    drive_request(cbf_pkg::CMD_PUT, 7'(run_len), 8'($urandom_range(255)));
                    for (k = 1; k < run_len; k++) begin
                        if ($urandom_range(99) < 10) begin
                            drive_request(cbf_pkg::CMD_GET, 7'($urandom_range(4)),
                                          8'($urandom_range(255)));
                            sent++;
                        end
                        drive_request(cbf_pkg::CMD_PUT, 7'($urandom_range(127)),
                                      8'($urandom_range(255)));
                    end
                    sent += (run_len == 0) ? 1 : run_len;
                end else begin
                    // get, mostly for bytes that are there
                    span = (bytes_held > 64) ? 64 : bytes_held;
                    pick = $urandom_range(99);
                    if (pick < 75 && span > 0) begin
                        run_len = $urandom_range(1, span);
                    end else if (pick < 85) begin
                        run_len = 0;
                    end else if (pick < 95) begin
                        run_len = bytes_held + $urandom_range(1, 8);
                    end else begin
                        run_len = $urandom_range(65, 127);
                    end
                    if (run_len > 127) begin
                        run_len = 127;
                    end
                    drive_request(cbf_pkg::CMD_GET, 7'(run_len), 8'($urandom_range(255)));
                    sent++;
                end
            end
        end

        // drain and verdict
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("byte_ring_buffer_block_transfer_test: done, clean");
        end else begin
            $display("byte_ring_buffer_block_transfer_test: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cbf_pkg.sv
hw/rtl/cbf_read_stage.sv
hw/rtl/byte_ring_buffer_block_transfer.sv
verif/byte_ring_buffer_block_transfer_checker.sv
verif/byte_ring_buffer_block_transfer_test.sv
